// File: rtl/dsc_pkg.sv
// Shared types, constants and codes for the drive and servo command decoder.
`timescale 1ns / 1ps
`default_nettype none

package dsc_pkg;

   // Configuration register indexes
   localparam int CsrIndexW = 2;
   localparam logic [CsrIndexW-1:0] CsrPwmPeriod = 2'd0;
   localparam logic [CsrIndexW-1:0] CsrDeadLow   = 2'd1;
   localparam logic [CsrIndexW-1:0] CsrDeadHigh  = 2'd2;
   localparam int CsrDataW = 16;

   // Configuration reset values
   localparam logic [15:0] PwmPeriodReset = 16'd20000;
   localparam logic [11:0] DeadLowReset   = 12'd1800;
   localparam logic [11:0] DeadHighReset  = 12'd2200;

   // Packet tags
   localparam logic [7:0] TagJoyFirst  = 8'h58; // 'X'
   localparam logic [7:0] TagJoySecond = 8'h59; // 'Y'
   localparam logic [7:0] TagBtnFirst  = 8'h42; // 'B'
   localparam logic [7:0] TagBtnSecond = 8'h54; // 'T'

   // Button codes
   localparam logic [7:0] KeyUp      = 8'h55; // 'U'
   localparam logic [7:0] KeyDown    = 8'h44; // 'D'
   localparam logic [7:0] KeyRight   = 8'h52; // 'R'
   localparam logic [7:0] KeyLeft    = 8'h4C; // 'L'
   localparam logic [7:0] KeyCenter  = 8'h57; // 'W'
   localparam logic [7:0] KeyLampOn  = 8'h4A; // 'J'
   localparam logic [7:0] KeyLampOff = 8'h4D; // 'M'

   // Drive constants
   localparam logic [15:0] TurnXMax  = 16'd4200;
   localparam logic [15:0] TurnScale = 16'd4200;
   localparam logic [11:0] DutyDiv   = 12'd4095;
   localparam logic [3:0]  PinsFwd   = 4'b1001;
   localparam logic [3:0]  PinsBwd   = 4'b0110;

   // Servo limits and steps
   localparam logic [11:0] TiltMin  = 12'd1800;
   localparam logic [11:0] TiltMid  = 12'd2350;
   localparam logic [11:0] TiltMax  = 12'd2500;
   localparam logic [11:0] TiltUp   = 12'd5;
   localparam logic [11:0] TiltDown = 12'd20;
   localparam logic [11:0] PanMin   = 12'd1500;
   localparam logic [11:0] PanMid   = 12'd2300;
   localparam logic [11:0] PanMax   = 12'd3300;
   localparam logic [11:0] PanRight = 12'd20;
   localparam logic [11:0] PanLeft  = 12'd5;

   // Command queue depth (power of two)
   localparam int QueueDepth = 4;
   localparam int QueuePtrW  = $clog2(QueueDepth);

   typedef struct packed {
      logic [7:0] tag_first;
      logic [7:0] tag_second;
      logic [7:0] byte_two;
      logic [7:0] byte_three;
      logic [7:0] byte_four;
      logic [7:0] byte_five;
   } req_type;

   typedef struct packed {
      logic [3:0]  bridge_pins;
      logic [20:0] motor_duty;
      logic        motor_written;
      logic [11:0] tilt_duty;
      logic [11:0] pan_duty;
      logic        servo_written;
      logic        lamps_on;
   } rsp_type;

   typedef enum logic [1:0] {
      CMD_OTHER,
      CMD_DRIVE,
      CMD_BUTTON
   } cmd_kind_type;

   typedef enum logic [2:0] {
      BTN_NONE,
      BTN_UP,
      BTN_DOWN,
      BTN_RIGHT,
      BTN_LEFT,
      BTN_CENTER,
      BTN_LAMP_ON,
      BTN_LAMP_OFF
   } button_type;

   // Classified packet: operand is the value to scale by the PWM period
   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   pins;
      logic [15:0]  operand;
      button_type   button;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

// File: rtl/drive_and_servo_command_decoder.sv
// Top level of the drive and servo command decoder.
`timescale 1ns / 1ps
`default_nettype none

// Takes one 6-byte radio packet per transaction and returns exactly one
// result per packet, in order. A joystick packet ('X','Y', x, y big-endian)
// sets the H-bridge pins and the shared motor duty, operand*pwm_period/4095;
// a button packet ('B','T', code) steps or recenters the camera servos or
// switches the lamps. Every result carries the full held state plus flags
// telling whether this packet wrote the motor or a servo. Other packets
// return the held state with both flags low.
// Rate: one packet per clock sustained while results are popped as they
// appear. From accept to rsp_* a packet passes through the command
// queue, then the product stage (16x16 multiply) and the quotient estimate
// stage of the divide by 4095, with the final correction feeding the result
// register. The 4-entry command queue and the single result register let
// the input keep flowing while a result waits to be popped.
// Configuration: csr_ready is always high; write only while idle. Register
// 0 is pwm_period, 1 dead_low, 2 dead_high; index 3 is ignored, data is
// truncated to register width.
module drive_and_servo_command_decoder (
   input  var logic                               clock,
   input  var logic                               reset,
   // packet input queue
   input  var logic                               req_push,
   output logic                                   req_full,
   input  var dsc_pkg::req_type                   req_data,
   // result queue
   output logic                                   rsp_empty,
   input  var logic                               rsp_pop,
   output dsc_pkg::rsp_type                       rsp_data,
   // register writes
   input  var logic                               csr_valid,
   output logic                                   csr_ready,
   input  var logic [dsc_pkg::CsrIndexW-1:0]      csr_index,
   input  var logic [dsc_pkg::CsrDataW-1:0]       csr_data
);
   import dsc_pkg::*;

   logic [15:0]       pwm_period_ff;
   logic [11:0]       dead_low_ff;
   logic [11:0]       dead_high_ff;
   cmd_type           front_cmd;
   cmd_type           queue_cmd;
   queue_status_type  q_status;
   logic              q_pop;

   assign csr_ready = 1'b1;
   assign req_full  = q_status.full;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         pwm_period_ff <= PwmPeriodReset;
         dead_low_ff   <= DeadLowReset;
         dead_high_ff  <= DeadHighReset;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CsrPwmPeriod: pwm_period_ff <= csr_data;
            CsrDeadLow:   dead_low_ff   <= csr_data[11:0];
            CsrDeadHigh:  dead_high_ff  <= csr_data[11:0];
            default:      ;
         endcase
      end
   end

   // classify incoming packet
   dsc_front u_front (
      .req_data  (req_data),
      .dead_low  (dead_low_ff),
      .dead_high (dead_high_ff),
      .cmd       (front_cmd)
   );

   // decouples packet acceptance from the execution pipe
   dsc_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (front_cmd),
      .pop       (q_pop),
      .pop_data  (queue_cmd),
      .status    (q_status)
   );

   // duty scaling and state update
   dsc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .pwm_period (pwm_period_ff),
      .q_status   (q_status),
      .cmd        (queue_cmd),
      .q_pop      (q_pop),
      .rsp_pop    (rsp_pop),
      .rsp_empty  (rsp_empty),
      .rsp_data   (rsp_data)
   );

   // a packet is either drive or button, never both
   a_one_writer: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> !(rsp_data.motor_written && rsp_data.servo_written))
      else $error("motor and servo written by the same transaction");

   // 65535*65535/4095 bounds the scaled duty
   a_duty_bound: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> rsp_data.motor_duty <= 21'd1048800)
      else $error("motor duty beyond full-scale quotient");

   // servo steps keep the duties inside their travel
   a_servo_range: assert property (@(posedge clock) disable iff (reset)
      !rsp_empty |-> (rsp_data.tilt_duty >= 12'd1785 && rsp_data.tilt_duty <= TiltMax &&
                      rsp_data.pan_duty >= PanMin && rsp_data.pan_duty <= 12'd3315))
      else $error("servo duty out of travel");

   // queue cannot be both full and empty
   a_queue_status: assert property (@(posedge clock) disable iff (reset)
      !(q_status.full && q_status.empty))
      else $error("command queue status inconsistent");

endmodule

`default_nettype wire

// File: rtl/dsc_front.sv
// Front end: decodes one packet into a drive, button or other command.
`timescale 1ns / 1ps
`default_nettype none

module dsc_front (
   input  var dsc_pkg::req_type req_data,
   input  var logic [11:0]      dead_low,
   input  var logic [11:0]      dead_high,
   output dsc_pkg::cmd_type     cmd
);
   import dsc_pkg::*;

   logic [15:0] x;
   logic [15:0] y;
   logic [15:0] dl;
   logic [15:0] dh;
   logic        right;
   logic        left;
   logic        back;
   logic        active;
   logic [3:0]  pins;

   assign x  = {req_data.byte_two, req_data.byte_three};
   assign y  = {req_data.byte_four, req_data.byte_five};
   assign dl = {4'b0, dead_low};
   assign dh = {4'b0, dead_high};

   assign right  = (x >= dh) && (x <= TurnXMax);
   assign left   = !right && (x <= dl);
   assign back   = (y <= dl);
   assign active = (y >= dh) || (y <= dl) || (x >= dh) || (x <= dl);

   always_comb begin
      pins = back ? PinsBwd : PinsFwd;
      if (active && right) begin
         pins = (pins & 4'b0111) | 4'b0010;
      end else if (active && left) begin
         pins = (pins | 4'b0100) & 4'b1110;
      end
   end

   always_comb begin
      cmd.kind    = CMD_OTHER;
      cmd.pins    = pins;
      cmd.operand = '0;
      cmd.button  = BTN_NONE;
      if (req_data.tag_first == TagJoyFirst && req_data.tag_second == TagJoySecond) begin
         cmd.kind = CMD_DRIVE;
         // zero operand gives zero duty inside the dead zone
         priority if (!active) begin
            cmd.operand = '0;
         end else if (right || left) begin
            cmd.operand = TurnScale;
         end else if (back) begin
            cmd.operand = TurnScale - y;
         end else begin
            cmd.operand = y;
         end
      end else if (req_data.tag_first == TagBtnFirst &&
                   req_data.tag_second == TagBtnSecond) begin
         cmd.kind = CMD_BUTTON;
         unique case (req_data.byte_two)
            KeyUp:      cmd.button = BTN_UP;
            KeyDown:    cmd.button = BTN_DOWN;
            KeyRight:   cmd.button = BTN_RIGHT;
            KeyLeft:    cmd.button = BTN_LEFT;
            KeyCenter:  cmd.button = BTN_CENTER;
            KeyLampOn:  cmd.button = BTN_LAMP_ON;
            KeyLampOff: cmd.button = BTN_LAMP_OFF;
            default:    cmd.button = BTN_NONE;
         endcase
      end
   end

endmodule

`default_nettype wire

// File: rtl/dsc_fifo.sv
// Small register queue of decoded commands between front and back end.
`timescale 1ns / 1ps
`default_nettype none

module dsc_fifo (
   input  var logic                      clock,
   input  var logic                      reset,
   input  var logic                      push,
   input  var dsc_pkg::cmd_type          push_data,
   input  var logic                      pop,
   output dsc_pkg::cmd_type              pop_data,
   output dsc_pkg::queue_status_type     status
);
   import dsc_pkg::*;

   cmd_type                entry_ff [QueueDepth];
   logic [QueuePtrW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QueuePtrW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QueuePtrW:0]     count_ff, count_in;
   logic                   do_push;
   logic                   do_pop;

   assign status.full  = (count_ff == (QueuePtrW+1)'(QueueDepth));
   assign status.empty = (count_ff == '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && !status.empty;
   assign pop_data     = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// File: rtl/dsc_back.sv
// Back end: duty scaling pipeline, held drive/servo/lamp state, result register.
`timescale 1ns / 1ps
`default_nettype none

module dsc_back (
   input  var logic                      clock,
   input  var logic                      reset,
   input  var logic [15:0]               pwm_period,
   input  var dsc_pkg::queue_status_type q_status,
   input  var dsc_pkg::cmd_type          cmd,
   output logic                          q_pop,
   input  var logic                      rsp_pop,
   output logic                          rsp_empty,
   output dsc_pkg::rsp_type              rsp_data
);
   import dsc_pkg::*;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   pins;
      button_type   button;
      logic [31:0]  product;
   } mul_stage_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [3:0]   pins;
      button_type   button;
      logic [20:0]  quot;
      logic [12:0]  prod_lo;
   } div_stage_type;

   logic          advance;
   logic          s1_valid_ff, s1_valid_in;
   logic          s2_valid_ff, s2_valid_in;
   logic          out_valid_ff, out_valid_in;
   mul_stage_type s1_ff, s1_in;
   div_stage_type s2_ff, s2_in;
   rsp_type       rsp_ff, rsp_in;

   logic [3:0]    pin_ff, pin_in;
   logic [20:0]   duty_ff, duty_in;
   logic [11:0]   tilt_ff, tilt_in;
   logic [11:0]   pan_ff, pan_in;
   logic          lamp_ff, lamp_in;

   logic [32:0]   est_sum;
   logic [12:0]   rem;
   logic [20:0]   quot_fix;
   logic          motor_wr;
   logic          servo_wr;

   // whole pipeline moves together when the result slot is free or being taken
   assign advance   = !out_valid_ff || rsp_pop;
   assign q_pop     = advance && !q_status.empty;
   assign rsp_empty = !out_valid_ff;
   assign rsp_data  = rsp_ff;

   // stage 1: 16x16 product
   always_comb begin
      s1_valid_in     = q_pop;
      s1_in.kind      = cmd.kind;
      s1_in.pins      = cmd.pins;
      s1_in.button    = cmd.button;
      s1_in.product   = 32'(cmd.operand) * 32'(pwm_period);
   end

   // stage 2: quotient estimate for /4095 = /4096 * (1 + 2^-12 + 2^-24 ...)
   // low by at most one
   always_comb begin
      est_sum = {1'b0, s1_ff.product} + {13'b0, s1_ff.product[31:12]} +
                {25'b0, s1_ff.product[31:24]};
      s2_valid_in   = s1_valid_ff;
      s2_in.kind    = s1_ff.kind;
      s2_in.pins    = s1_ff.pins;
      s2_in.button  = s1_ff.button;
      s2_in.quot    = est_sum[32:12];
      s2_in.prod_lo = s1_ff.product[12:0];
   end

   // stage 3: remainder is below 2*4095, so 13 bits of p - 4095*q suffice
   always_comb begin
      rem      = s2_ff.prod_lo - {s2_ff.quot[0], 12'b0} + s2_ff.quot[12:0];
      quot_fix = (rem >= {1'b0, DutyDiv}) ? s2_ff.quot + 21'd1 : s2_ff.quot;
   end

   always_comb begin
      pin_in   = pin_ff;
      duty_in  = duty_ff;
      tilt_in  = tilt_ff;
      pan_in   = pan_ff;
      lamp_in  = lamp_ff;
      motor_wr = 1'b0;
      servo_wr = 1'b0;
      if (advance && s2_valid_ff) begin
         unique case (s2_ff.kind)
            CMD_DRIVE: begin
               pin_in   = s2_ff.pins;
               duty_in  = quot_fix;
               motor_wr = 1'b1;
            end
            CMD_BUTTON: begin
               unique case (s2_ff.button)
                  BTN_UP: begin
                     if (tilt_ff < TiltMax) begin
                        tilt_in  = tilt_ff + TiltUp;
                        servo_wr = 1'b1;
                     end
                  end
                  BTN_DOWN: begin
                     if (tilt_ff > TiltMin) begin
                        tilt_in  = tilt_ff - TiltDown;
                        servo_wr = 1'b1;
                     end
                  end
                  BTN_RIGHT: begin
                     if (pan_ff < PanMax) begin
                        pan_in   = pan_ff + PanRight;
                        servo_wr = 1'b1;
                     end
                  end
                  BTN_LEFT: begin
                     if (pan_ff > PanMin) begin
                        pan_in   = pan_ff - PanLeft;
                        servo_wr = 1'b1;
                     end
                  end
                  BTN_CENTER: begin
                     tilt_in  = TiltMid;
                     pan_in   = PanMid;
                     servo_wr = 1'b1;
                  end
                  BTN_LAMP_ON:  lamp_in = 1'b1;
                  BTN_LAMP_OFF: lamp_in = 1'b0;
                  BTN_NONE:     ;
               endcase
            end
            CMD_OTHER: ;
            default: ;
         endcase
      end
   end

   always_comb begin
      out_valid_in         = advance ? s2_valid_ff : out_valid_ff;
      rsp_in.bridge_pins   = pin_in;
      rsp_in.motor_duty    = duty_in;
      rsp_in.motor_written = motor_wr;
      rsp_in.tilt_duty     = tilt_in;
      rsp_in.pan_duty      = pan_in;
      rsp_in.servo_written = servo_wr;
      rsp_in.lamps_on      = lamp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         pin_ff       <= PinsFwd;
         duty_ff      <= '0;
         tilt_ff      <= TiltMid;
         pan_ff       <= PanMid;
         lamp_ff      <= 1'b0;
      end else begin
         if (advance) begin
            s1_valid_ff <= s1_valid_in;
            s2_valid_ff <= s2_valid_in;
         end
         out_valid_ff <= out_valid_in;
         pin_ff       <= pin_in;
         duty_ff      <= duty_in;
         tilt_ff      <= tilt_in;
         pan_ff       <= pan_in;
         lamp_ff      <= lamp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
      end
      if (advance && s2_valid_ff) begin
         rsp_ff <= rsp_in;
      end
   end

endmodule

`default_nettype wire
